// ===== rtl/spvm_pkg.sv =====
// Shared constants, types and a helper function for the sample playback voice mixer.
`timescale 1ns / 1ps
`default_nettype none

package spvm_pkg;

    // Request kinds carried in tuser
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_SWRITE = 2'd2;

    // Voice event selectors
    localparam logic [2:0] EV_POS  = 3'd0;
    localparam logic [2:0] EV_VOL  = 3'd1;
    localparam logic [2:0] EV_STEP = 3'd2;
    localparam logic [2:0] EV_LOOP = 3'd3;
    localparam logic [2:0] EV_LEN  = 3'd4;

    // Reset values of the voice record and the master gain
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;
    localparam logic [31:0] VOL_RESET  = 32'h0000_4000;
    localparam logic [15:0] MVOL_RESET = 16'd768;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Saturated accumulator and scaled result widths
    localparam int SAT_W = 49;
    localparam int RES_W = 42;

    localparam logic signed [SAT_W-1:0] ACC_LIMIT   = 49'sh0_8000_0000_0000;
    localparam logic signed [SAT_W-1:0] ACC_LIMIT_N = 49'sh1_8000_0000_0000;

    localparam logic signed [RES_W-1:0] RES_MAX = 42'sd8388607;
    localparam logic signed [RES_W-1:0] RES_MIN = -42'sd8388608;

    // One stereo word of a sample store, left in the low half
    typedef struct packed {
        logic signed [15:0] right;
        logic signed [15:0] left;
    } spvm_sample_t;

    // Clamp a scaled result to 24-bit signed
    function automatic logic [23:0] clamp24(input logic signed [RES_W-1:0] r);
        logic [23:0] q;
        if (r > RES_MAX)
        begin
            q = 24'h7F_FFFF;
        end
        else if (r < RES_MIN)
        begin
            q = 24'h80_0000;
        end
        else
        begin
            q = r[23:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sample_playback_voice_mixer.sv =====
// Top level of the multi-voice stereo sample playback mixer.
//
// A request on the slave stream is a frame tick, a voice event or a sample write
// (tuser kind). A tick advances every active voice by its step, wraps or stops it
// at the end of its sample, sums volume times sample over the active voices for
// left and right, scales by master_volume (Q8.8) and returns one 24-bit stereo
// result on the master stream. Events and sample writes return nothing. The
// block takes one request at a time; tready is high only between requests. A
// tick waits at its end while the previous result has not yet been taken. The
// sequencing follows from the voice record RAM, which is read and written back
// once per active voice, and the one shared 33 x 17 multiplier, which serves
// the two mixing products of each contributing voice and the four products of
// the master scaling. Voice records reset through a valid bit per voice, so
// there is no clearing pass; the sample stores are not initialised and must be
// written before they are played. master_volume may be written at any time
// through cfg_wr_en / cfg_wr_data, but only between requests to keep results
// well defined.
`timescale 1ns / 1ps
`default_nettype none

module sample_playback_voice_mixer
    import spvm_pkg::*;
#(
    parameter int VOICES       = 8,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // voice[2:0], value[34:3], address[50:35], sample_left[66:51],
    // sample_right[82:67], zero fill [87:83]
    input  wire  [87:0] s_axis_tdata,
    // kind[1:0], event_req[4:2]
    input  wire  [4:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // mix_left[23:0], mix_right[47:24]
    output logic [47:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VX        = ((VW > 3) ? VW : 3) + 1;
    localparam int LW        = $clog2(SAMPLE_DEPTH + 1);
    localparam int N_W       = (LW > 16) ? LW : 16;
    localparam int CMP_W     = (LW + 16 > 33) ? (LW + 16) : 33;
    localparam int MEM_DEPTH = VOICES * SAMPLE_DEPTH;
    localparam int MAW       = $clog2(MEM_DEPTH);
    localparam int A_W       = ((MAW > 16) ? MAW : 16) + 1;
    localparam int REC_W     = 96 + LW;
    localparam int ACC_W     = SAT_W + $clog2(VOICES);

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_E_RD  = 5'd1;
    localparam logic [4:0] S_E_UPD = 5'd2;
    localparam logic [4:0] S_SW    = 5'd3;
    localparam logic [4:0] S_T_RD  = 5'd4;
    localparam logic [4:0] S_T_ADV = 5'd5;
    localparam logic [4:0] S_T_WB  = 5'd6;
    localparam logic [4:0] S_T_SRD = 5'd7;
    localparam logic [4:0] S_T_ML  = 5'd8;
    localparam logic [4:0] S_T_MR  = 5'd9;
    localparam logic [4:0] S_T_ACR = 5'd10;
    localparam logic [4:0] S_F_SAT = 5'd11;
    localparam logic [4:0] S_F_MHL = 5'd12;
    localparam logic [4:0] S_F_MLL = 5'd13;
    localparam logic [4:0] S_F_ADL = 5'd14;
    localparam logic [4:0] S_F_MLR = 5'd15;
    localparam logic [4:0] S_F_ADR = 5'd16;
    localparam logic [4:0] S_F_OUT = 5'd17;

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic [1:0]    in_kind;
    logic [2:0]    in_req;
    logic [2:0]    in_voice;
    logic [31:0]   in_value;
    logic [15:0]   in_addr;
    logic [15:0]   in_sl;
    logic [15:0]   in_sr;
    logic [VX-1:0] in_vwide;
    logic [VW-1:0] in_vidx;
    logic          voice_ok;
    logic          addr_ok;

    assign in_kind  = s_axis_tuser[1:0];
    assign in_req   = s_axis_tuser[4:2];
    assign in_voice = s_axis_tdata[2:0];
    assign in_value = s_axis_tdata[34:3];
    assign in_addr  = s_axis_tdata[50:35];
    assign in_sl    = s_axis_tdata[66:51];
    assign in_sr    = s_axis_tdata[82:67];

    assign in_vwide = VX'(in_voice);
    assign in_vidx  = in_vwide[VW-1:0];
    assign voice_ok = in_vwide < VX'(VOICES);
    assign addr_ok  = N_W'(in_addr) < N_W'(SAMPLE_DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // control
    logic [4:0]        state_reg,     state_next;
    logic [VW-1:0]     vsel_reg,      vsel_next;
    logic [VOICES-1:0] active_reg,    active_next;
    logic [VOICES-1:0] loop_reg,      loop_next;
    logic [VOICES-1:0] vvalid_reg,    vvalid_next;
    logic [15:0]       mvol_reg,      mvol_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [2:0]               req_reg,       req_next;
    logic [31:0]              value_reg,     value_next;
    logic [15:0]              addr_reg,      addr_next;
    spvm_sample_t             swr_reg,       swr_next;
    logic                     rec_valid_reg, rec_valid_next;
    logic [MAW-1:0]           base_reg,      base_next;
    logic signed [33:0]       psum_reg,      psum_next;
    logic [31:0]              newpos_reg,    newpos_next;
    logic signed [ACC_W-1:0]  acc_l_reg,     acc_l_next;
    logic signed [ACC_W-1:0]  acc_r_reg,     acc_r_next;
    logic signed [SAT_W-1:0]  sat_l_reg,     sat_l_next;
    logic signed [SAT_W-1:0]  sat_r_reg,     sat_r_next;
    logic signed [RES_W-1:0]  hi_reg,        hi_next;
    logic signed [RES_W-1:0]  res_l_reg,     res_l_next;
    logic signed [RES_W-1:0]  res_r_reg,     res_r_next;
    logic [23:0]              out_l_reg,     out_l_next;
    logic [23:0]              out_r_reg,     out_r_next;
    logic signed [PROD_W-1:0] prod_reg;

    // ------------------------------------------------------------------
    // Voice record RAM: {length, volume, step, position}
    // ------------------------------------------------------------------
    logic             vram_we;
    logic [REC_W-1:0] vram_wdata;
    logic             vram_re;
    logic [REC_W-1:0] vram_rdata;

    spvm_ram #(
        .WIDTH (REC_W),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .clk     (clk),
        .wr_en   (vram_we),
        .wr_addr (vsel_reg),
        .wr_data (vram_wdata),
        .rd_en   (vram_re),
        .rd_addr (vsel_reg),
        .rd_data (vram_rdata)
    );

    // An unwritten record reads as its reset value
    logic [31:0]   vr_pos;
    logic [31:0]   vr_step;
    logic [31:0]   vr_vol;
    logic [LW-1:0] vr_len;

    assign vr_pos  = rec_valid_reg ? vram_rdata[31:0]       : 32'd0;
    assign vr_step = rec_valid_reg ? vram_rdata[63:32]      : STEP_RESET;
    assign vr_vol  = rec_valid_reg ? vram_rdata[95:64]      : VOL_RESET;
    assign vr_len  = rec_valid_reg ? vram_rdata[REC_W-1:96] : '0;

    // ------------------------------------------------------------------
    // Sample store RAM, one region of SAMPLE_DEPTH words per voice
    // ------------------------------------------------------------------
    logic           smp_we;
    logic [MAW-1:0] smp_waddr;
    logic           smp_re;
    logic [MAW-1:0] smp_raddr;
    spvm_sample_t   smp_rdata;
    logic [A_W-1:0] smp_waddr_full;
    logic [A_W-1:0] smp_raddr_full;

    assign smp_waddr_full = A_W'(vsel_reg) * A_W'(SAMPLE_DEPTH) + A_W'(addr_reg);
    assign smp_waddr      = smp_waddr_full[MAW-1:0];
    assign smp_raddr_full = A_W'(base_reg) + A_W'(newpos_reg[31:16]);
    assign smp_raddr      = smp_raddr_full[MAW-1:0];

    spvm_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_sample_ram (
        .clk     (clk),
        .wr_en   (smp_we),
        .wr_addr (smp_waddr),
        .wr_data (swr_reg),
        .rd_en   (smp_re),
        .rd_addr (smp_raddr),
        .rd_data (smp_rdata)
    );

    // ------------------------------------------------------------------
    // Voice event update: restart rule first, then the selected field
    // ------------------------------------------------------------------
    logic          ev_restart;
    logic [31:0]   ev_pos;
    logic [31:0]   ev_step;
    logic [31:0]   ev_vol;
    logic [LW-1:0] ev_len;
    logic          ev_act;
    logic          ev_loop;
    logic [N_W-1:0] ev_len_raw;

    always_comb
    begin
        ev_restart = !loop_reg[vsel_reg] &&
                     (!active_reg[vsel_reg] ||
                      (CMP_W'(vr_pos) >= CMP_W'({vr_len, 16'h0000})));
        ev_pos     = ev_restart ? 32'd0 : vr_pos;
        ev_act     = ev_restart ? 1'b1 : active_reg[vsel_reg];
        ev_loop    = loop_reg[vsel_reg];
        ev_step    = vr_step;
        ev_vol     = vr_vol;
        ev_len     = vr_len;
        ev_len_raw = value_reg[31] ? '0 : N_W'(value_reg[31:16]);
        case (req_reg)
            EV_POS:
            begin
                if (value_reg[31])
                begin
                    ev_pos = 32'd0;
                    ev_act = 1'b0;
                end
                else
                begin
                    ev_pos = value_reg;
                    ev_act = 1'b1;
                end
            end
            EV_VOL:  ev_vol  = value_reg;
            EV_STEP: ev_step = value_reg;
            EV_LOOP: ev_loop = |value_reg;
            EV_LEN:
            begin
                // clamp the integer part to the store depth
                ev_len = (ev_len_raw > N_W'(SAMPLE_DEPTH)) ? LW'(SAMPLE_DEPTH)
                                                           : LW'(ev_len_raw);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Tick advance: below zero stops the voice, past the end wraps or stops
    // ------------------------------------------------------------------
    logic        tk_past;
    logic [31:0] tk_pos;
    logic        tk_act;
    logic        tk_contrib;

    always_comb
    begin
        tk_past = CMP_W'(psum_reg[32:0]) >= CMP_W'({vr_len, 16'h0000});
        if (psum_reg[33])
        begin
            tk_pos = 32'd0;
            tk_act = 1'b0;
        end
        else if (tk_past)
        begin
            tk_pos = 32'd0;
            tk_act = loop_reg[vsel_reg];
        end
        else
        begin
            tk_pos = psum_reg[31:0];
            tk_act = 1'b1;
        end
        // silent when the read index is at or past the length
        tk_contrib = N_W'(newpos_reg[31:16]) < N_W'(vr_len);
    end

    // ------------------------------------------------------------------
    // Accumulator saturation to +/- 2^47
    // ------------------------------------------------------------------
    function automatic logic signed [SAT_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a);
        logic signed [SAT_W-1:0] q;
        if (a > ACC_W'(ACC_LIMIT))
        begin
            q = ACC_LIMIT;
        end
        else if (a < ACC_W'(ACC_LIMIT_N))
        begin
            q = ACC_LIMIT_N;
        end
        else
        begin
            q = SAT_W'(a);
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Shared multiplier: mixing products, then the master scaling split
    // into a high part (signed, bits 48:24) and a low part (bits 23:0)
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_B_W-1:0] mvol_op;

    assign mvol_op = $signed({1'b0, mvol_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T_ML:
            begin
                mul_a = MUL_A_W'($signed(vr_vol));
                mul_b = MUL_B_W'(smp_rdata.left);
            end
            S_T_MR:
            begin
                mul_a = MUL_A_W'($signed(vr_vol));
                mul_b = MUL_B_W'(smp_rdata.right);
            end
            S_F_MHL:
            begin
                mul_a = MUL_A_W'($signed(sat_l_reg[48:24]));
                mul_b = mvol_op;
            end
            S_F_MLL:
            begin
                mul_a = $signed({9'b0, sat_l_reg[23:0]});
                mul_b = mvol_op;
            end
            S_F_ADL:
            begin
                mul_a = MUL_A_W'($signed(sat_r_reg[48:24]));
                mul_b = mvol_op;
            end
            S_F_MLR:
            begin
                mul_a = $signed({9'b0, sat_r_reg[23:0]});
                mul_b = mvol_op;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic next_voice;

    always_comb
    begin
        state_next     = state_reg;
        vsel_next      = vsel_reg;
        active_next    = active_reg;
        loop_next      = loop_reg;
        vvalid_next    = vvalid_reg;
        mvol_next      = cfg_wr_en ? cfg_wr_data : mvol_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        req_next       = req_reg;
        value_next     = value_reg;
        addr_next      = addr_reg;
        swr_next       = swr_reg;
        rec_valid_next = rec_valid_reg;
        base_next      = base_reg;
        psum_next      = psum_reg;
        newpos_next    = newpos_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        sat_l_next     = sat_l_reg;
        sat_r_next     = sat_r_reg;
        hi_next        = hi_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;

        vram_we    = 1'b0;
        vram_re    = 1'b0;
        vram_wdata = {vr_len, vr_vol, vr_step, tk_pos};
        smp_we     = 1'b0;
        smp_re     = 1'b0;
        next_voice = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next       = in_req;
                    value_next     = in_value;
                    addr_next      = in_addr;
                    swr_next.left  = $signed(in_sl);
                    swr_next.right = $signed(in_sr);
                    vsel_next      = in_vidx;
                    case (in_kind)
                        KIND_TICK:
                        begin
                            vsel_next  = '0;
                            base_next  = '0;
                            acc_l_next = '0;
                            acc_r_next = '0;
                            state_next = S_T_RD;
                        end
                        KIND_EVENT:
                        begin
                            if (voice_ok)
                            begin
                                state_next = S_E_RD;
                            end
                        end
                        KIND_SWRITE:
                        begin
                            if (voice_ok && addr_ok)
                            begin
                                state_next = S_SW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_E_RD:
            begin
                vram_re        = 1'b1;
                rec_valid_next = vvalid_reg[vsel_reg];
                state_next     = S_E_UPD;
            end
            S_E_UPD:
            begin
                vram_we               = 1'b1;
                vram_wdata            = {ev_len, ev_vol, ev_step, ev_pos};
                vvalid_next[vsel_reg] = 1'b1;
                active_next[vsel_reg] = ev_act;
                loop_next[vsel_reg]   = ev_loop;
                state_next            = S_IDLE;
            end
            S_SW:
            begin
                smp_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_T_RD:
            begin
                if (active_reg[vsel_reg])
                begin
                    vram_re        = 1'b1;
                    rec_valid_next = vvalid_reg[vsel_reg];
                    state_next     = S_T_ADV;
                end
                else
                begin
                    next_voice = 1'b1;
                end
            end
            S_T_ADV:
            begin
                psum_next  = $signed({2'b00, vr_pos}) + 34'($signed(vr_step));
                state_next = S_T_WB;
            end
            S_T_WB:
            begin
                vram_we               = 1'b1;
                vvalid_next[vsel_reg] = 1'b1;
                active_next[vsel_reg] = tk_act;
                newpos_next           = tk_pos;
                state_next            = S_T_SRD;
            end
            S_T_SRD:
            begin
                if (active_reg[vsel_reg] && tk_contrib)
                begin
                    smp_re     = 1'b1;
                    state_next = S_T_ML;
                end
                else
                begin
                    next_voice = 1'b1;
                end
            end
            S_T_ML:
            begin
                state_next = S_T_MR;
            end
            S_T_MR:
            begin
                acc_l_next = acc_l_reg + ACC_W'(prod_reg);
                state_next = S_T_ACR;
            end
            S_T_ACR:
            begin
                acc_r_next = acc_r_reg + ACC_W'(prod_reg);
                next_voice = 1'b1;
            end
            S_F_SAT:
            begin
                sat_l_next = sat_acc(acc_l_reg);
                sat_r_next = sat_acc(acc_r_reg);
                state_next = S_F_MHL;
            end
            S_F_MHL:
            begin
                state_next = S_F_MLL;
            end
            S_F_MLL:
            begin
                hi_next    = prod_reg[RES_W-1:0];
                state_next = S_F_ADL;
            end
            S_F_ADL:
            begin
                res_l_next = hi_reg + RES_W'($signed({1'b0, prod_reg[39:24]}));
                state_next = S_F_MLR;
            end
            S_F_MLR:
            begin
                hi_next    = prod_reg[RES_W-1:0];
                state_next = S_F_ADR;
            end
            S_F_ADR:
            begin
                res_r_next = hi_reg + RES_W'($signed({1'b0, prod_reg[39:24]}));
                state_next = S_F_OUT;
            end
            S_F_OUT:
            begin
                // hold until the output register is free or draining
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_l_next     = clamp24(res_l_reg);
                    out_r_next     = clamp24(res_r_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next voice, or finish the frame after the last one
        if (next_voice)
        begin
            if (vsel_reg == VW'(VOICES - 1))
            begin
                state_next = S_F_SAT;
            end
            else
            begin
                vsel_next  = vsel_reg + 1'b1;
                base_next  = base_reg + MAW'(SAMPLE_DEPTH);
                state_next = S_T_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vsel_reg      <= '0;
            active_reg    <= '1;
            loop_reg      <= '0;
            vvalid_reg    <= '0;
            mvol_reg      <= MVOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vsel_reg      <= vsel_next;
            active_reg    <= active_next;
            loop_reg      <= loop_next;
            vvalid_reg    <= vvalid_next;
            mvol_reg      <= mvol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        value_reg     <= value_next;
        addr_reg      <= addr_next;
        swr_reg       <= swr_next;
        rec_valid_reg <= rec_valid_next;
        base_reg      <= base_next;
        psum_reg      <= psum_next;
        newpos_reg    <= newpos_next;
        acc_l_reg     <= acc_l_next;
        acc_r_reg     <= acc_r_next;
        sat_l_reg     <= sat_l_next;
        sat_r_reg     <= sat_r_next;
        hi_reg        <= hi_next;
        res_l_reg     <= res_l_next;
        res_r_reg     <= res_r_next;
        out_l_reg     <= out_l_next;
        out_r_reg     <= out_r_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_r_reg, out_l_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The voice pointer stays inside the voice range while a request is in work
    a_vsel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (VX'(vsel_reg) < VX'(VOICES)))
        else $error("voice pointer beyond the last voice");

    // A sample store is read only for a voice that is still playing
    a_read_active: assert property (@(posedge clk) disable iff (!rst_n)
        smp_re |-> active_reg[vsel_reg])
        else $error("sample read for a stopped voice");

    // A sample write stays inside the store
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        smp_we |-> ({1'b0, smp_waddr} < (MAW + 1)'(MEM_DEPTH)))
        else $error("sample write beyond the store");

    // A waiting result is never overwritten: the frame holds at its end
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_F_OUT) && out_valid_reg && !m_axis_tready)
        |=> (state_reg == S_F_OUT))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== rtl/spvm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              clk,
    input  wire              wr_en,
    input  wire  [AW-1:0]    wr_addr,
    input  wire  [WIDTH-1:0] wr_data,
    input  wire              rd_en,
    input  wire  [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
